// File: rtl/core/fltw_pkg.sv
// Shared types and constants for the four-level page table walker.
// No dependencies; imported by the controller, the datapath and the top level.
package fltw_pkg;

	// Field widths
	localparam int CMD_W   = 2;
	localparam int VA_W    = 48;
	localparam int PA_W    = 52;
	localparam int FLAGS_W = 12;
	localparam int OFF_W   = 12;
	localparam int IDX_W   = 9;
	localparam int FRAME_W = 40;
	localparam int ENTRY_W = 52;
	localparam int LVL_W   = 2;

	localparam int ENTRIES         = 1 << IDX_W;
	localparam int TABLE_PAGES_DEF = 64;

	// Bit position of the index field at each level
	localparam int SHIFT_L0 = 39;
	localparam int SHIFT_L1 = 30;
	localparam int SHIFT_L2 = 21;
	localparam int SHIFT_L3 = 12;

	// Command codes; code 3 is a no-op
	localparam logic [CMD_W-1:0] CMD_MAP   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_XLATE = 2'd2;

	localparam logic [LVL_W-1:0] LVL_LEAF = 2'd3;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_NO_MEM = 1'b1;

	// Entry flag bits: present, write, user
	localparam logic [OFF_W-1:0] ENT_PRESENT     = 12'h001;
	localparam logic [OFF_W-1:0] ENT_TABLE_FLAGS = 12'h007;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_ZERO,
		ST_LINK,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic sweep_all;
		logic sweep_slot;
		logic rd;
		logic wr_leaf;
		logic wr_zero;
		logic link;
		logic descend;
		logic set_nomem;
		logic set_xlate;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [LVL_W-1:0] lvl;
		logic             present;
		logic             in_range;
		logic             alloc_ok;
		logic             dirty;
		logic             all_last;
		logic             slot_last;
	} dp_sts_t;

endpackage

// File: rtl/core/fltw_ctrl.sv
// Walk sequencer for the page table walker: reset sweep, level walk, allocation.
// Depends on fltw_pkg; drives fltw_dp through dp_cmd_t and reads dp_sts_t.
module fltw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output fltw_pkg::dp_cmd_t dp_cmd,
	input  fltw_pkg::dp_sts_t dp_sts
);
	import fltw_pkg::*;

	state_t state_q, state_nx;
	logic   out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Output word register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (dp_sts.all_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nx = ST_READ;
			end
			ST_READ: begin
				case (dp_sts.cmd)
					CMD_MAP, CMD_UNMAP: begin
						state_nx = (dp_sts.lvl == LVL_LEAF) ? ST_DONE : ST_EVAL;
					end
					CMD_XLATE: state_nx = ST_EVAL;
					default:   state_nx = ST_DONE;
				endcase
			end
			ST_EVAL: begin
				if (dp_sts.lvl == LVL_LEAF) begin
					state_nx = ST_DONE;
				end else if (dp_sts.present && dp_sts.in_range) begin
					state_nx = ST_READ;
				end else if (!dp_sts.present && dp_sts.cmd == CMD_MAP && dp_sts.alloc_ok) begin
					state_nx = dp_sts.dirty ? ST_ZERO : ST_LINK;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_ZERO: begin
				if (dp_sts.slot_last) state_nx = ST_LINK;
			end
			ST_LINK: state_nx = ST_READ;
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_nx = ST_IDLE;
			end
			default: state_nx = ST_CLEAR;
		endcase
	end

	// Datapath commands
	always_comb begin
		dp_cmd = '0;
		case (state_q)
			ST_CLEAR: dp_cmd.sweep_all = 1'b1;
			ST_IDLE:  dp_cmd.load_in = in_valid;
			ST_READ: begin
				case (dp_sts.cmd)
					CMD_MAP: begin
						if (dp_sts.lvl == LVL_LEAF) dp_cmd.wr_leaf = 1'b1;
						else dp_cmd.rd = 1'b1;
					end
					CMD_UNMAP: begin
						if (dp_sts.lvl == LVL_LEAF) dp_cmd.wr_zero = 1'b1;
						else dp_cmd.rd = 1'b1;
					end
					CMD_XLATE: dp_cmd.rd = 1'b1;
					default: ;
				endcase
			end
			ST_EVAL: begin
				if (dp_sts.lvl == LVL_LEAF) begin
					dp_cmd.set_xlate = 1'b1;
				end else if (dp_sts.present && dp_sts.in_range) begin
					dp_cmd.descend = 1'b1;
				end else if (dp_sts.cmd == CMD_MAP) begin
					// table out of reach, or a new one needed with the store full
					if (dp_sts.present || !dp_sts.alloc_ok) dp_cmd.set_nomem = 1'b1;
				end
			end
			ST_ZERO: dp_cmd.sweep_slot = 1'b1;
			ST_LINK: dp_cmd.link = 1'b1;
			ST_DONE: dp_cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

endmodule

// File: rtl/core/fltw_dp.sv
// Datapath of the page table walker: table store, walk registers, allocator.
// Depends on fltw_pkg; sequenced by fltw_ctrl.
module fltw_dp #(
	parameter int TABLE_PAGES = fltw_pkg::TABLE_PAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fltw_pkg::CMD_W-1:0]    cmd,
	input  logic [fltw_pkg::VA_W-1:0]     virt_addr,
	input  logic [fltw_pkg::PA_W-1:0]     phys_addr,
	input  logic [fltw_pkg::FLAGS_W-1:0]  flags,
	input  logic                          cfg_we,
	input  logic [fltw_pkg::FRAME_W-1:0]  cfg_wdata,
	input  fltw_pkg::dp_cmd_t             dp_cmd,
	output fltw_pkg::dp_sts_t             dp_sts,
	output logic                          status,
	output logic [fltw_pkg::PA_W-1:0]     phys_result
);
	import fltw_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_PAGES);
	localparam int NF_W   = SLOT_W + 1;
	localparam int ADDR_W = SLOT_W + IDX_W;
	localparam int DEPTH  = TABLE_PAGES * ENTRIES;

	localparam logic [NF_W-1:0]    TP_NF     = NF_W'(TABLE_PAGES);
	localparam logic [FRAME_W-1:0] TP_FRAME  = FRAME_W'(TABLE_PAGES);
	localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(ENTRIES - 1);

	// Captured command word
	logic [CMD_W-1:0]   cmd_q;
	logic [VA_W-1:0]    va_q;
	logic [PA_W-1:0]    pa_q;
	logic [FLAGS_W-1:0] fl_q;

	logic [FRAME_W-1:0] base_q;
	logic [SLOT_W-1:0]  cur_q;
	logic [LVL_W-1:0]   lvl_q;
	logic [NF_W-1:0]    nf_q;
	logic               dirty_q;
	logic [ADDR_W-1:0]  clr_cnt_q;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic               res_status_q, out_status_q;
	logic [PA_W-1:0]    res_phys_q, out_phys_q;

	logic [IDX_W-1:0]   idx;
	logic [FRAME_W-1:0] rel;
	logic [FRAME_W-1:0] alloc_frame;
	logic               present, in_range, stray, sweep_last;
	logic [ADDR_W-1:0]  mem_addr;
	logic               mem_we;
	logic [ENTRY_W-1:0] mem_wdata;

	// Input capture
	always_ff @(posedge clk) begin
		if (dp_cmd.load_in) begin
			cmd_q <= cmd;
			va_q  <= virt_addr;
			pa_q  <= phys_addr;
			fl_q  <= flags;
		end
	end

	// Pool base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// Index field of the current level
	always_comb begin
		case (lvl_q)
			2'd0:    idx = va_q[SHIFT_L0 +: IDX_W];
			2'd1:    idx = va_q[SHIFT_L1 +: IDX_W];
			2'd2:    idx = va_q[SHIFT_L2 +: IDX_W];
			default: idx = va_q[SHIFT_L3 +: IDX_W];
		endcase
	end

	// Decode of the entry just read
	assign rel         = rd_q[PA_W-1:OFF_W] - base_q;
	assign present     = |(rd_q[OFF_W-1:0] & ENT_PRESENT);
	assign in_range    = (rel < TP_FRAME);
	assign alloc_frame = base_q + FRAME_W'(nf_q);
	// write into a slot the allocator has not handed out yet
	assign stray       = ({1'b0, cur_q} >= nf_q);
	assign sweep_last  = dp_cmd.sweep_all ? (clr_cnt_q == LAST_ADDR)
	                                      : (clr_cnt_q[IDX_W-1:0] == LAST_IDX);

	// Store port: address and write data
	always_comb begin
		mem_addr  = {cur_q, idx};
		mem_we    = 1'b0;
		mem_wdata = '0;
		if (dp_cmd.sweep_all) begin
			mem_addr = clr_cnt_q;
			mem_we   = 1'b1;
		end else if (dp_cmd.sweep_slot) begin
			mem_addr = {nf_q[SLOT_W-1:0], clr_cnt_q[IDX_W-1:0]};
			mem_we   = 1'b1;
		end else if (dp_cmd.link) begin
			mem_we    = 1'b1;
			mem_wdata = {alloc_frame, ENT_TABLE_FLAGS};
		end else if (dp_cmd.wr_leaf) begin
			mem_we    = 1'b1;
			mem_wdata = {pa_q[PA_W-1:OFF_W], fl_q | ENT_PRESENT};
		end else if (dp_cmd.wr_zero) begin
			mem_we = 1'b1;
		end
	end

	// Table store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (dp_cmd.rd) rd_q <= mem[mem_addr];
	end

	// Sweep counter, back to zero after each sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (dp_cmd.sweep_all || dp_cmd.sweep_slot) begin
			clr_cnt_q <= sweep_last ? '0 : clr_cnt_q + 1'b1;
		end
	end

	// Walk position and allocator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			lvl_q <= '0;
			nf_q  <= NF_W'(1);
		end else if (dp_cmd.load_in) begin
			cur_q <= '0;
			lvl_q <= '0;
		end else if (dp_cmd.descend) begin
			cur_q <= rel[SLOT_W-1:0];
			lvl_q <= lvl_q + 1'b1;
		end else if (dp_cmd.link) begin
			cur_q <= nf_q[SLOT_W-1:0];
			lvl_q <= lvl_q + 1'b1;
			nf_q  <= nf_q + 1'b1;
		end
	end

	// Sticky mark: an unallocated slot may no longer be all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b0;
		end else if ((dp_cmd.link || dp_cmd.wr_leaf) && stray) begin
			dirty_q <= 1'b1;
		end
	end

	// Result of the current command
	always_ff @(posedge clk) begin
		if (dp_cmd.load_in) begin
			res_status_q <= STATUS_OK;
			res_phys_q   <= '0;
		end else if (dp_cmd.set_nomem) begin
			res_status_q <= STATUS_NO_MEM;
		end else if (dp_cmd.set_xlate && present) begin
			res_phys_q <= {rd_q[PA_W-1:OFF_W], va_q[OFF_W-1:0]};
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			out_status_q <= res_status_q;
			out_phys_q   <= res_phys_q;
		end
	end

	assign status      = out_status_q;
	assign phys_result = out_phys_q;

	assign dp_sts.cmd       = cmd_q;
	assign dp_sts.lvl       = lvl_q;
	assign dp_sts.present   = present;
	assign dp_sts.in_range  = in_range;
	assign dp_sts.alloc_ok  = (nf_q < TP_NF);
	assign dp_sts.dirty     = dirty_q;
	assign dp_sts.all_last  = (clr_cnt_q == LAST_ADDR);
	assign dp_sts.slot_last = (clr_cnt_q[IDX_W-1:0] == LAST_IDX);

endmodule

// File: rtl/core/four_level_page_table_walker.sv
// Four-level page table walker with a local table store.
// Usage:
//   Input channel in_valid/in_ready carries one word: cmd (0 map, 1 unmap,
//   2 translate, 3 no-op), virt_addr, phys_addr, flags.
//   Output channel out_valid/out_ready returns one word per input word:
//   status (1 = map failed, store full or table outside it) and phys_result.
//   cfg_we/cfg_wdata write pool_base_frame; write only while the block is idle.
// Timing: one word at a time. Each level passes through a read state and an
//   evaluate state, sharing the single port of the table store; map and unmap
//   write the leaf in its read state and skip its evaluate. Each new table
//   adds a link state. After a map has written into a slot not yet handed
//   out, each later table allocation first zeroes the slot it hands out.
// Reset: every entry of the store is swept to zero, with in_ready low;
//   configuration writes are still taken.
// Stall: the result sits in an output register; the next word is accepted
//   while it waits, and that word's result holds until the register frees.
// Depends on fltw_pkg, fltw_ctrl and fltw_dp.
module four_level_page_table_walker #(
	parameter int TABLE_PAGES = fltw_pkg::TABLE_PAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fltw_pkg::CMD_W-1:0]    cmd,
	input  logic [fltw_pkg::VA_W-1:0]     virt_addr,
	input  logic [fltw_pkg::PA_W-1:0]     phys_addr,
	input  logic [fltw_pkg::FLAGS_W-1:0]  flags,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic [fltw_pkg::PA_W-1:0]     phys_result,
	input  logic                          cfg_we,
	input  logic [fltw_pkg::FRAME_W-1:0]  cfg_wdata
);
	import fltw_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// Sequencer
	fltw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	// Store and walk registers
	fltw_dp #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.flags       (flags),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.dp_cmd      (dp_cmd),
		.dp_sts      (dp_sts),
		.status      (status),
		.phys_result (phys_result)
	);

	// One word in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("word accepted while previous one in flight");

	// Store port carries at most one write source per cycle
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.sweep_all, dp_cmd.sweep_slot, dp_cmd.link,
		          dp_cmd.wr_leaf, dp_cmd.wr_zero}))
		else $error("conflicting writes to table store");

	// A result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> (!out_valid || out_ready))
		else $error("output word overwritten");

	// Descend only into a present table inside the store
	a_descend_ok: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.descend |-> (dp_sts.present && dp_sts.in_range && dp_sts.lvl != LVL_LEAF))
		else $error("walk descended into invalid table");

endmodule

// File: bench/tb_four_level_page_table_walker.sv
`timescale 1ns / 100ps
// Self-checking bench for four_level_page_table_walker: map, unmap and translate words,
// directed and random, checked against an in-bench model of the table store.
// Depends on fltw_pkg and the walker RTL; needs no files or arguments.
module tb_four_level_page_table_walker;
	import fltw_pkg::*;

	localparam int POOL_SLOTS = 64;
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_SLACK = 40;
	localparam int LIMIT_NS = 20_000_000;

	typedef struct {
		logic [CMD_W-1:0]   op;
		logic [VA_W-1:0]    va;
		logic [PA_W-1:0]    pa;
		logic [FLAGS_W-1:0] fl;
	} walk_word_t;

	typedef struct {
		logic            st;
		logic [PA_W-1:0] pr;
	} walk_result_t;

	typedef enum {JOB_WORD, JOB_CFG, JOB_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t          kind;
		walk_word_t         w;
		logic [FRAME_W-1:0] base;
	} job_t;

	// Block inputs, all known from time zero
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [CMD_W-1:0]   cmd = '0;
	logic [VA_W-1:0]    virt_addr = '0;
	logic [PA_W-1:0]    phys_addr = '0;
	logic [FLAGS_W-1:0] flags = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               status;
	logic [PA_W-1:0]    phys_result;
	logic               cfg_we = 1'b0;
	logic [FRAME_W-1:0] cfg_wdata = '0;

	four_level_page_table_walker #(
		.TABLE_PAGES(POOL_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.virt_addr(virt_addr),
		.phys_addr(phys_addr),
		.flags(flags),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.phys_result(phys_result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Model of the table store; a missing key reads as zero
	logic [PA_W-1:0]    table_mem [int unsigned];
	int unsigned        next_free_slot = 1;
	logic [FRAME_W-1:0] base_frame = '0;

	walk_result_t result_q[$];
	job_t         job_q[$];
	logic [26:0]  prefix_pool[$];
	logic [VA_W-1:0] mapped_va[$];

	int errors = 0;
	int n_checked = 0;
	int n_nomem = 0;
	int n_hits = 0;
	int n_cfg = 0;
	int op_count [4] = '{0, 0, 0, 0};

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [PA_W-1:0] entry_at(int unsigned slot, logic [IDX_W-1:0] idx);
		int unsigned key;
		key = slot * ENTRIES + idx;
		return table_mem.exists(key) ? table_mem[key] : '0;
	endfunction

	function automatic void clear_slot(int unsigned slot);
		int unsigned key;
		for (int i = 0; i < ENTRIES; i++) begin
			key = slot * ENTRIES + i;
			if (table_mem.exists(key))
				table_mem.delete(key);
		end
	endfunction

	// Present entry whose frame lands inside the store -> slot of the next table
	function automatic bit next_table(input logic [PA_W-1:0] ent, output int unsigned slot);
		logic [FRAME_W-1:0] rel;
		rel = ent[PA_W-1:OFF_W] - base_frame;
		slot = 32'(rel);
		return ((ent[OFF_W-1:0] & ENT_PRESENT) != '0) && (rel < POOL_SLOTS);
	endfunction

	// Apply one word to the model and return the result it should produce
	function automatic walk_result_t walk_tables(input walk_word_t w);
		walk_result_t       r;
		logic [IDX_W-1:0]   idx [4];
		logic [PA_W-1:0]    ent;
		logic [FRAME_W-1:0] frame;
		int unsigned        cur;
		bit                 ok;
		r.st = STATUS_OK;
		r.pr = '0;
		idx[0] = w.va[SHIFT_L0 +: IDX_W];
		idx[1] = w.va[SHIFT_L1 +: IDX_W];
		idx[2] = w.va[SHIFT_L2 +: IDX_W];
		idx[3] = w.va[SHIFT_L3 +: IDX_W];
		cur = 0;
		ok = 1'b1;
		if (w.op == CMD_MAP) begin
			// walk down, allocating missing tables from the bump pointer
			for (int lv = 0; lv < 3; lv++) begin
				if (ok) begin
					ent = entry_at(cur, idx[lv]);
					if ((ent[OFF_W-1:0] & ENT_PRESENT) == '0) begin
						if (next_free_slot >= POOL_SLOTS) begin
							ok = 1'b0;
						end else begin
							clear_slot(next_free_slot);
							frame = base_frame + FRAME_W'(next_free_slot);
							ent = {frame, ENT_TABLE_FLAGS};
							table_mem[cur * ENTRIES + idx[lv]] = ent;
							next_free_slot++;
						end
					end
					if (ok)
						ok = next_table(ent, cur);
				end
			end
			if (ok)
				table_mem[cur * ENTRIES + idx[3]] = {w.pa[PA_W-1:OFF_W], w.fl | ENT_PRESENT};
			else
				r.st = STATUS_NO_MEM;
		end else if (w.op == CMD_UNMAP || w.op == CMD_XLATE) begin
			// walk down without creating anything
			for (int lv = 0; lv < 3; lv++) begin
				if (ok)
					ok = next_table(entry_at(cur, idx[lv]), cur);
			end
			if (ok && w.op == CMD_UNMAP) begin
				table_mem[cur * ENTRIES + idx[3]] = '0;
			end else if (ok) begin
				ent = entry_at(cur, idx[3]);
				if ((ent[OFF_W-1:0] & ENT_PRESENT) != '0)
					r.pr = {ent[PA_W-1:OFF_W], w.va[OFF_W-1:0]};
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(3, 1);
		else if (r < 95)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic void add_word(input logic [CMD_W-1:0] op, input logic [VA_W-1:0] va,
			input logic [PA_W-1:0] pa, input logic [FLAGS_W-1:0] fl);
		job_t j;
		j.kind = JOB_WORD;
		j.w.op = op;
		j.w.va = va;
		j.w.pa = pa;
		j.w.fl = fl;
		j.base = '0;
		job_q.push_back(j);
		if (op == CMD_MAP)
			mapped_va.push_back(va);
	endfunction

	function automatic void add_sync(input job_kind_t kind, input logic [FRAME_W-1:0] base);
		job_t j;
		j.kind = kind;
		j.w = '{default: '0};
		j.base = base;
		job_q.push_back(j);
	endfunction

	// Mostly addresses under tables that exist, some fresh paths, a little noise
	function automatic walk_word_t random_word();
		walk_word_t  w;
		logic [63:0] r;
		logic [26:0] pfx;
		int          pick;
		int          lv;
		r = rand64();
		w.pa = r[PA_W-1:0];
		w.fl = r[63:PA_W];
		pick = $urandom_range(99);
		w.op = (pick < 40) ? CMD_MAP : (pick < 60) ? CMD_UNMAP : (pick < 96) ? CMD_XLATE : CMD_NOP;
		pick = $urandom_range(99);
		r = rand64();
		if (pick < 35 && mapped_va.size() > 0) begin
			w.va = mapped_va[$urandom_range(mapped_va.size() - 1)];
			w.va[OFF_W-1:0] = r[OFF_W-1:0];
		end else if (pick < 85) begin
			pfx = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
			w.va = {pfx, r[IDX_W+OFF_W-1:0]};
		end else if (pick < 96) begin
			pfx = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
			lv = $urandom_range(2);
			pfx[lv*IDX_W +: IDX_W] = r[40 +: IDX_W];
			prefix_pool.push_back(pfx);
			w.va = {pfx, r[IDX_W+OFF_W-1:0]};
		end else begin
			w.va = r[VA_W-1:0];
		end
		return w;
	endfunction

	function automatic void random_block(int n);
		walk_word_t w;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(119) == 0)
				add_sync(JOB_DRAIN, '0);
			w = random_word();
			add_word(w.op, w.va, w.pa, w.fl);
		end
	endfunction

	// Sender: words from job_q, base writes and drains only once the block is empty
	int         gap_left = 0;
	int         calm_left = 0;
	walk_word_t cur_word;

	always @(posedge clk) begin : drive_words
		logic         valid_nx;
		logic         we_nx;
		logic         drained;
		walk_result_t exp_r;
		if (arst_n) begin
			valid_nx = in_valid;
			we_nx = 1'b0;
			if (in_valid && in_ready) begin
				exp_r = walk_tables(cur_word);
				result_q.push_back(exp_r);
				op_count[cur_word.op]++;
				if (exp_r.st == STATUS_NO_MEM)
					n_nomem++;
				if (exp_r.pr != '0)
					n_hits++;
				valid_nx = 1'b0;
				if (calm_left > 0) begin
					calm_left--;
					gap_left = 0;
				end else begin
					gap_left = gap_len();
					if ($urandom_range(79) == 0)
						calm_left = $urandom_range(120, 40);
				end
			end
			drained = (result_q.size() == 0) && !(out_valid && out_ready);
			if (!valid_nx && job_q.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					case (job_q[0].kind)
						JOB_WORD: begin
							cur_word = job_q[0].w;
							cmd <= cur_word.op;
							virt_addr <= cur_word.va;
							phys_addr <= cur_word.pa;
							flags <= cur_word.fl;
							valid_nx = 1'b1;
							job_q.delete(0);
						end
						JOB_CFG: begin
							if (drained) begin
								we_nx = 1'b1;
								cfg_wdata <= job_q[0].base;
								base_frame = job_q[0].base;
								n_cfg++;
								job_q.delete(0);
							end
						end
						JOB_DRAIN: begin
							if (drained)
								job_q.delete(0);
						end
						default: ;
					endcase
				end
			end
			in_valid <= valid_nx;
			cfg_we <= we_nx;
		end
	end

	// Receiver: check each result word, stall at random, hold off long now and then
	int stall_left = 0;
	int quiet_left = 0;

	always @(posedge clk) begin : check_results
		walk_result_t exp_r;
		logic         rdy_nx;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: result word with nothing expected: status=%0b phys=%h",
						$time, status, phys_result);
					errors++;
				end else begin
					exp_r = result_q.pop_front();
					if (status !== exp_r.st) begin
						$display("%0t: status mismatch: expected %0b, got %0b",
							$time, exp_r.st, status);
						errors++;
					end
					if (phys_result !== exp_r.pr) begin
						$display("%0t: phys_result mismatch: expected %h, got %h",
							$time, exp_r.pr, phys_result);
						errors++;
					end
				end
				n_checked++;
				// long hold-off lets the walker back up and drop in_ready
				if (n_checked % 400 == 150) begin
					stall_left = LONG_HOLD;
				end else if (quiet_left > 0) begin
					quiet_left--;
					stall_left = 0;
				end else begin
					stall_left = gap_len();
					if ($urandom_range(79) == 0)
						quiet_left = $urandom_range(120, 40);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rdy_nx = 1'b0;
			end else begin
				rdy_nx = 1'b1;
			end
			out_ready <= rdy_nx;
		end
	end

	initial begin : run_test
		logic [VA_W-1:0]    ones48;
		logic [PA_W-1:0]    ones52;
		logic [63:0]        r;
		ones48 = '1;
		ones52 = '1;
		prefix_pool.push_back(27'h0);
		prefix_pool.push_back(27'h7FF_FFFF);
		prefix_pool.push_back(27'h400_0001);

		// Directed: extremes, every command, absent and partial paths, remap
		add_sync(JOB_CFG, '0);
		add_word(CMD_XLATE, 48'h0, '0, '0);
		add_word(CMD_UNMAP, 48'h0, '0, '0);
		add_word(CMD_MAP, 48'h0, ones52, 12'hFFF);
		add_word(CMD_XLATE, 48'h0000_0000_0FFF, '0, '0);
		add_word(CMD_MAP, ones48, '0, 12'h000);
		add_word(CMD_XLATE, ones48, ones52, 12'hFFF);
		add_word(CMD_MAP, 48'h0000_0000_1000, 52'h0_0000_0ABC_D123, 12'h0A4);
		add_word(CMD_XLATE, 48'h0000_0000_1234, '0, '0);
		add_word(CMD_MAP, 48'h0000_0000_1000, 52'h5_A5A5_5A5A_5FFF, 12'h002);
		add_word(CMD_XLATE, 48'h0000_0000_1FFF, '0, '0);
		add_word(CMD_UNMAP, 48'h0, '0, '0);
		add_word(CMD_XLATE, 48'h0, '0, '0);
		add_word(CMD_UNMAP, 48'h0000_0000_5000, '0, '0);
		add_word(CMD_XLATE, 48'h0000_4000_0000, '0, '0);
		add_word(CMD_UNMAP, 48'h0080_0000_0000, '0, '0);
		add_word(CMD_NOP, ones48, ones52, 12'hFFF);
		add_word(CMD_NOP, 48'h0, '0, '0);
		add_word(CMD_MAP, 48'h8000_0020_0000, 52'hA_BCDE_F012_3000, 12'h800);
		add_word(CMD_XLATE, 48'h8000_0020_07FF, '0, '0);
		add_word(CMD_XLATE, 48'h0000_0000_1000, '0, '0);

		// Random phases under different base frames, extremes included
		random_block(440);
		add_sync(JOB_CFG, '1);
		random_block(230);
		r = rand64();
		add_sync(JOB_CFG, r[FRAME_W-1:0]);
		random_block(190);
		add_sync(JOB_CFG, 40'h1);
		random_block(210);
		add_sync(JOB_CFG, '0);
		random_block(260);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (job_q.size() > 0 || in_valid)
			@(negedge clk);
		while (result_q.size() > 0)
			@(negedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);

		$display("Checked %0d result words: %0d map, %0d unmap, %0d translate, %0d no-op.",
			n_checked, op_count[CMD_MAP], op_count[CMD_UNMAP], op_count[CMD_XLATE],
			op_count[CMD_NOP]);
		$display("%0d maps refused, %0d translations hit, %0d base writes, %0d slots used.",
			n_nomem, n_hits, n_cfg, next_free_slot);
		if (errors == 0 && result_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_NS);
		$display("Run did not finish in time: %0d words still expected", result_q.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
